/* src/profile_switch_with_delay_core_macros.svh */
// assertion macros for the profile switch core
// used by the files that carry concurrent checks; expects i_clk and i_rst_n in scope
`ifndef PROFILE_SWITCH_WITH_DELAY_CORE_MACROS_SVH
`define PROFILE_SWITCH_WITH_DELAY_CORE_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define PSWD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("pswd check failed");

// consequence that must hold in the cycle after the antecedent
`define PSWD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pswd check failed");

`else

`define PSWD_ASSERT(lbl, prop)
`define PSWD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* src/pswd_pkg.sv */
// shared types, codes and constants of the profile switch core
// no dependencies; imported by all modules here but pswd_ram

package pswd_pkg;

    // sizing
    localparam int CONTROLLERS = 4;
    localparam int PROFILES    = 8;
    localparam int CTL_W       = 2;
    localparam int PRF_W       = 3;
    localparam int ADDR_W      = CTL_W + PRF_W;
    localparam int TRIG_DEPTH  = CONTROLLERS * PROFILES;

    // field widths
    localparam int CMD_W    = 2;
    localparam int KIND_W   = 2;
    localparam int DTYPE_W  = 2;
    localparam int DNUM_W   = 8;
    localparam int CODE_W   = 9;
    localparam int DELAY_W  = 16;
    localparam int PERIOD_W = 20;

    // refresh period and whole milliseconds via reciprocal multiply
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 20'd10000;
    localparam int MS_W     = 11;
    localparam int MS_SHIFT = 30;
    localparam int RECIP_W  = 21;
    localparam logic [RECIP_W-1:0] MS_RECIP = 21'd1073742;
    localparam int PROD_W   = PERIOD_W + RECIP_W;
    localparam logic [MS_W-1:0] MS_RST = 11'd10;

    // serial divider
    localparam int DIV_STEPS = DELAY_W;
    localparam int DCNT_W    = 4;

    // command codes of an input transaction
    localparam logic [CMD_W-1:0] CMD_EVENT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_WACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EVENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [CTL_W-1:0]   controller;
        logic [PRF_W-1:0]   entry;
        logic [DTYPE_W-1:0] src_type;
        logic [DNUM_W-1:0]  src_num;
        logic [CODE_W-1:0]  button_code;
        logic               released;
        logic               back_flag;
        logic [DELAY_W-1:0] delay_ms;
        logic               entry_present;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CTL_W-1:0]   which_controller;
        logic               hit;
        logic [PRF_W-1:0]   profile;
        logic [PRF_W-1:0]   prior_profile;
        logic [DELAY_W-1:0] delay_ticks;
        logic               last;
    } t_out_item;

    // one trigger table entry as stored in the ram
    typedef struct packed {
        logic               present;
        logic [DTYPE_W-1:0] dev_type;
        logic [DNUM_W-1:0]  dev_num;
        logic [CODE_W-1:0]  code;
        logic               back;
        logic [DELAY_W-1:0] delay;
    } t_trig;

    localparam int TRIG_W = $bits(t_trig);

    // which result the datapath builds on an emit
    typedef enum logic [2:0] {
        RES_WACK      = 3'd0,
        RES_EVENT     = 3'd1,
        RES_MISS      = 3'd2,
        RES_TICK      = 3'd3,
        RES_TICK_NONE = 3'd4
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic delay_rd;
        logic div_load;
        logic div_step;
        logic tick_step;
        logic emit;
        t_res res;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_hit;
        logic scan_miss;
        logic div_last;
        logic tick_commit;
        logic tick_last;
        logic tick_any;
        logic out_free;
    } t_dp_stat;

endpackage

/* src/pswd_ram.sv */
// generic single write port ram with registered read
// no dependencies

module pswd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/pswd_ctrl.sv */
// controller state machine of the profile switch core
// depends on pswd_pkg; drives the datapath through t_dp_cmd

module pswd_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [pswd_pkg::CMD_W-1:0] i_in_cmd,
    output logic                       o_in_stall,
    input  pswd_pkg::t_dp_stat         i_stat,
    output pswd_pkg::t_dp_cmd          o_cmd
);

    import pswd_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DRD   = 7'b0000100,
        S_DLOAD = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_TICK  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_res   r_res, n_res;

    // input side is open only between transactions
    assign o_in_stall = (r_state != S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state        = r_state;
        n_res          = r_res;
        o_cmd          = '0;
        o_cmd.res      = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_in_cmd)
                        CMD_EVENT: n_state = S_SCAN;
                        CMD_TICK:  n_state = S_TICK;
                        CMD_WRITE: begin
                            n_state = S_EMIT;
                            n_res   = RES_WACK;
                        end
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_hit) begin
                    n_state = S_DRD;
                end else if (i_stat.scan_miss) begin
                    n_state = S_EMIT;
                    n_res   = RES_MISS;
                end
            end
            S_DRD: begin
                o_cmd.delay_rd = 1'b1;
                n_state        = S_DLOAD;
            end
            S_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_EMIT;
                    n_res   = RES_EVENT;
                end
            end
            S_TICK: begin
                if (i_stat.tick_commit) begin
                    n_state = S_EMIT;
                    n_res   = RES_TICK;
                end else begin
                    o_cmd.tick_step = 1'b1;
                    if (i_stat.tick_last) begin
                        if (i_stat.tick_any) begin
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_EMIT;
                            n_res   = RES_TICK_NONE;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_res == RES_TICK && !i_stat.tick_last) begin
                        n_state = S_TICK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res   <= RES_WACK;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

endmodule

/* src/pswd_dp.sv */
// datapath of the profile switch core: trigger ram, per controller state,
// table scan, delay divider and output register; depends on pswd_pkg and pswd_ram
`include "profile_switch_with_delay_core_macros.svh"

module pswd_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pswd_pkg::PERIOD_W-1:0] i_cfg_wdata,
    input  pswd_pkg::t_in_item            i_in,
    input  pswd_pkg::t_dp_cmd             i_cmd,
    output pswd_pkg::t_dp_stat            o_stat,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pswd_pkg::t_out_item           o_out
);

    import pswd_pkg::*;

    // transaction and configuration
    t_in_item            r_item;
    logic [PERIOD_W-1:0] r_period;
    logic [MS_W-1:0]     r_ms;
    logic [PROD_W-1:0]   ms_prod;
    logic [MS_W-1:0]     ms_eff;

    // trigger ram and its written marks
    logic [TRIG_DEPTH-1:0] r_vld;
    logic                  r_rd_vld;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [TRIG_W-1:0]     ram_rdata;
    logic                  ram_we;
    t_trig                 trig;
    t_trig                 wtrig;
    logic                  wr_ok;

    // per controller state
    logic [PRF_W-1:0]   r_act  [CONTROLLERS];
    logic [PRF_W-1:0]   r_pend [CONTROLLERS];
    logic [PRF_W-1:0]   r_earl [CONTROLLERS];
    logic [DELAY_W-1:0] r_cnt  [CONTROLLERS];
    logic [CONTROLLERS-1:0] r_pv;
    logic [CONTROLLERS-1:0] commit_vec;

    // scan and tick
    logic [CTL_W-1:0]  r_c;
    logic              r_any;
    logic [ADDR_W-1:0] r_pos;
    logic [ADDR_W-1:0] r_epos;
    logic              r_ev;
    logic              r_has;
    logic [PRF_W-1:0]  r_sel;
    logic [CTL_W-1:0]  ev_c;
    logic [PRF_W-1:0]  ev_j;
    logic [CTL_W-1:0]  rd_c;
    logic [PRF_W-1:0]  base;
    logic              match;
    logic              cur_has;
    logic              new_has;
    logic [PRF_W-1:0]  new_sel;
    logic              brk;
    logic              ev_now;
    logic              last_ent;
    logic              last_ctl;

    // divider
    logic [DELAY_W-1:0] r_quo;
    logic [MS_W-1:0]    r_rem;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [MS_W:0]      trial;
    logic [MS_W:0]      diff;
    logic               ge;

    // output
    t_out_item r_out;
    logic      r_out_vld;
    t_out_item res_item;
    logic      out_free;

    // configuration register and whole milliseconds of it
    assign ms_prod = PROD_W'(r_period) * PROD_W'(MS_RECIP);
    assign ms_eff  = (r_ms == '0) ? MS_W'(1) : r_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_ms     <= MS_RST;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            r_ms <= ms_prod[MS_SHIFT +: MS_W];
        end
    end

    // transaction latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in;
        end
    end

    // trigger ram write on the write acknowledge
    assign wr_ok     = ({1'b0, r_item.controller} < (CTL_W + 1)'(CONTROLLERS))
                    && ({1'b0, r_item.entry} < (PRF_W + 1)'(PROFILES));
    assign ram_we    = i_cmd.emit && (i_cmd.res == RES_WACK) && wr_ok;
    assign ram_waddr = {r_item.controller, r_item.entry};
    assign ram_raddr = i_cmd.delay_rd ? {r_c, r_sel} : r_pos;

    always_comb begin
        wtrig          = '0;
        wtrig.present  = r_item.entry_present;
        wtrig.dev_type = r_item.src_type;
        wtrig.dev_num  = r_item.src_num;
        wtrig.code     = r_item.button_code;
        wtrig.back     = r_item.back_flag;
        wtrig.delay    = r_item.delay_ms;
    end

    pswd_ram #(
        .WIDTH (TRIG_W),
        .DEPTH (TRIG_DEPTH)
    ) u_trig_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wtrig),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // written marks, an unwritten entry reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[ram_raddr];
        end
    end

    assign trig = r_rd_vld ? t_trig'(ram_rdata) : '0;

    // scan evaluation of the entry read in the previous cycle
    assign {ev_c, ev_j} = r_epos;
    assign rd_c     = i_cmd.scan ? ev_c : r_c;
    assign base     = r_pv[rd_c] ? r_pend[rd_c] : r_act[rd_c];
    assign match    = trig.present && (trig.dev_type == r_item.src_type)
                   && (trig.dev_num == r_item.src_num)
                   && (trig.code == r_item.button_code);
    assign cur_has  = (ev_j != '0) && r_has;
    assign ev_now   = i_cmd.scan && r_ev;
    assign last_ent = (ev_j == PRF_W'(PROFILES - 1));
    assign last_ctl = (ev_c == CTL_W'(CONTROLLERS - 1));

    always_comb begin
        new_has = cur_has;
        new_sel = r_sel;
        brk     = 1'b0;
        if (match) begin
            if (r_item.released) begin
                // first switch-back trigger returns to the earlier profile
                if (trig.back) begin
                    new_has = 1'b1;
                    new_sel = r_earl[rd_c];
                    brk     = 1'b1;
                end
            end else if (ev_j != base) begin
                // cyclic next after the base
                if (!cur_has) begin
                    new_has = 1'b1;
                    new_sel = ev_j;
                end else if (r_sel < base && ev_j > base) begin
                    new_sel = ev_j;
                end
            end
        end
    end

    // scan pointers and selection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
        end else if (i_cmd.accept) begin
            r_ev <= 1'b0;
        end else if (i_cmd.scan) begin
            r_ev <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pos <= '0;
        end else if (i_cmd.scan) begin
            r_pos  <= r_pos + 1'b1;
            r_epos <= r_pos;
        end
        if (ev_now) begin
            r_has <= new_has;
            r_sel <= new_sel;
        end
    end

    // controller index shared by scan result, tick walk and emits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c   <= '0;
            r_any <= 1'b0;
        end else if (i_cmd.accept) begin
            r_c   <= '0;
            r_any <= 1'b0;
        end else if (o_stat.scan_hit) begin
            r_c <= ev_c;
        end else if (i_cmd.tick_step || (i_cmd.emit && i_cmd.res == RES_TICK)) begin
            r_c <= r_c + 1'b1;
            if (i_cmd.emit) begin
                r_any <= 1'b1;
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    assign trial = {r_rem, r_quo[DELAY_W-1]};
    assign diff  = trial - {1'b0, ms_eff};
    assign ge    = (trial >= {1'b0, ms_eff});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_quo  <= trig.delay;
            r_rem  <= '0;
            r_dcnt <= DCNT_W'(DIV_STEPS - 1);
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[DELAY_W-2:0], ge};
            r_rem  <= ge ? diff[MS_W-1:0] : trial[MS_W-1:0];
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    // per controller state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
            for (int i = 0; i < CONTROLLERS; i++) begin
                r_act[i]  <= '0;
                r_pend[i] <= '0;
                r_earl[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else if (i_cmd.emit && i_cmd.res == RES_EVENT) begin
            r_pend[r_c] <= r_sel;
            r_pv[r_c]   <= 1'b1;
            r_cnt[r_c]  <= r_quo;
        end else if (i_cmd.emit && i_cmd.res == RES_TICK) begin
            r_earl[r_c] <= r_act[r_c];
            r_act[r_c]  <= r_pend[r_c];
            r_pv[r_c]   <= 1'b0;
        end else if (i_cmd.tick_step && r_pv[r_c]) begin
            r_cnt[r_c] <= r_cnt[r_c] - 1'b1;
        end
    end

    // controllers due to commit on this tick
    always_comb begin
        for (int i = 0; i < CONTROLLERS; i++) begin
            commit_vec[i] = r_pv[i] && (r_cnt[i] == '0);
        end
    end

    // result builder
    always_comb begin
        res_item = '0;
        case (i_cmd.res)
            RES_WACK: begin
                res_item.kind             = KIND_WACK;
                res_item.which_controller = r_item.controller;
                res_item.hit              = wr_ok;
                res_item.profile          = r_item.entry;
                res_item.last             = 1'b1;
            end
            RES_EVENT: begin
                res_item.kind             = KIND_EVENT;
                res_item.which_controller = r_c;
                res_item.hit              = 1'b1;
                res_item.profile          = r_sel;
                res_item.prior_profile    = r_act[r_c];
                res_item.delay_ticks      = r_quo;
                res_item.last             = 1'b1;
            end
            RES_MISS: begin
                res_item.kind = KIND_EVENT;
                res_item.last = 1'b1;
            end
            RES_TICK: begin
                res_item.kind             = KIND_TICK;
                res_item.which_controller = r_c;
                res_item.hit              = 1'b1;
                res_item.profile          = r_pend[r_c];
                res_item.prior_profile    = r_act[r_c];
                res_item.last             = ((commit_vec >> r_c) >> 1) == '0;
            end
            default: begin
                res_item.kind = KIND_TICK;
                res_item.last = 1'b1;
            end
        endcase
    end

    // output register
    assign out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= res_item;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // status to the controller
    assign o_stat.scan_hit    = ev_now && (brk || (last_ent && new_has));
    assign o_stat.scan_miss   = ev_now && !brk && last_ent && !new_has && last_ctl;
    assign o_stat.div_last    = (r_dcnt == '0);
    assign o_stat.tick_commit = commit_vec[r_c];
    assign o_stat.tick_last   = (r_c == CTL_W'(CONTROLLERS - 1));
    assign o_stat.tick_any    = r_any;
    assign o_stat.out_free    = out_free;

    // checks
    `PSWD_ASSERT(a_emit_into_free, !i_cmd.emit || out_free)
    `PSWD_ASSERT(a_no_step_on_due, !i_cmd.tick_step || !commit_vec[r_c])
    `PSWD_ASSERT_NEXT(a_event_pends, i_cmd.emit && i_cmd.res == RES_EVENT, r_pv[$past(r_c)])
    `PSWD_ASSERT_NEXT(a_commit_clears, i_cmd.emit && i_cmd.res == RES_TICK, !r_pv[$past(r_c)])

endmodule

/* src/profile_switch_with_delay_core.sv */
// top level of the profile switch core: controller plus datapath
// depends on pswd_pkg, pswd_ctrl, pswd_dp (and pswd_ram below it)
//
//   channel   handshake                  payload
//   input     i_in_valid / o_in_stall    i_in  (t_in_item)
//   output    o_out_valid / i_out_stall  o_out (t_out_item)
//   config    i_cfg_we                   i_cfg_wdata (refresh period, us)
//
// one transaction at a time; the next is taken once the current one has
// handed its last result to the output register
// button event: table scan of one ram read a cycle, then one delay read and
// a serial divide of the delay by the whole milliseconds of the period
// tick: a walk over the controllers after the accept, with an emit for each
// committed controller, or one empty tick emit if none; trigger write: accept
// plus a ram writing emit; a stalled output holds the block in its emit step
// reset clears the written marks of all 32 table entries and every controller

module profile_switch_with_delay_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pswd_pkg::PERIOD_W-1:0] i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pswd_pkg::t_in_item            i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pswd_pkg::t_out_item           o_out
);

    import pswd_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencing
    pswd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // table, state, divider and output register
    pswd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
